[src/htv_pkg.sv]
// ----------------------------------------------------------------------------
// htv_pkg
// Shared types, constants and the commutation successor lookup for the
// Hall transition validator.
// ----------------------------------------------------------------------------
package htv_pkg;

	localparam int CODE_W     = 3;
	localparam int STAMP_W    = 32;
	localparam int MIN_W      = 16;
	localparam int COUNT_W    = 32;
	localparam int NUM_ERR    = 5;
	localparam int ERR_IDX_W  = $clog2(NUM_ERR);

	localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(5);

	// Codes that never appear on a healthy sensor set
	localparam logic [CODE_W-1:0] CODE_ALL_LOW  = 3'b000;
	localparam logic [CODE_W-1:0] CODE_ALL_HIGH = 3'b111;

	// One-bit change masks
	localparam logic [CODE_W-1:0] BIT_U = 3'h1;
	localparam logic [CODE_W-1:0] BIT_V = 3'h2;
	localparam logic [CODE_W-1:0] BIT_W = 3'h4;

	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	typedef enum logic [2:0] {
		ST_VALID      = 3'd0,
		ST_TOO_SOON   = 3'd1,
		ST_MULTI_BIT  = 3'd2,
		ST_WRONG_CW   = 3'd3,
		ST_WRONG_CCW  = 3'd4,
		ST_IMPOSSIBLE = 3'd5
	} status_t;

	// Classifier decision for one edge
	typedef struct packed {
		status_t status;
		logic    upd_time;
		logic    upd_code;
	} verdict_t;

	// Next code in the six-step sequence; all-low and all-high have none
	function automatic logic [CODE_W-1:0] successor(input logic [CODE_W-1:0] code,
	                                                 input logic dir);
		logic [CODE_W-1:0] nxt;
		nxt = CODE_ALL_LOW;
		if (dir == DIR_CW) begin
			unique case (code)
				3'd1:    nxt = 3'd3;
				3'd2:    nxt = 3'd6;
				3'd3:    nxt = 3'd2;
				3'd4:    nxt = 3'd5;
				3'd5:    nxt = 3'd1;
				3'd6:    nxt = 3'd4;
				default: nxt = CODE_ALL_LOW;
			endcase
		end else begin
			unique case (code)
				3'd1:    nxt = 3'd5;
				3'd2:    nxt = 3'd3;
				3'd3:    nxt = 3'd1;
				3'd4:    nxt = 3'd6;
				3'd5:    nxt = 3'd4;
				3'd6:    nxt = 3'd2;
				default: nxt = CODE_ALL_LOW;
			endcase
		end
		return nxt;
	endfunction

endpackage

[src/htv_if.sv]
// ----------------------------------------------------------------------------
// htv_if
// Valid/ready channels of the Hall transition validator: edge requests,
// verdict requests and the interval register write.
// ----------------------------------------------------------------------------
interface htv_edge_if;
	logic                          valid;
	logic                          ready;
	logic [htv_pkg::CODE_W-1:0]    hall_code;
	logic [htv_pkg::STAMP_W-1:0]   timestamp;
	logic                          direction;

	modport source(output valid, hall_code, timestamp, direction, input ready);
	modport sink(input valid, hall_code, timestamp, direction, output ready);
endinterface

interface htv_verdict_if;
	logic                          valid;
	logic                          ready;
	htv_pkg::status_t              status;
	logic [htv_pkg::COUNT_W-1:0]   error_count;

	modport source(output valid, status, error_count, input ready);
	modport sink(input valid, status, error_count, output ready);
endinterface

interface htv_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [htv_pkg::MIN_W-1:0]     min_edge_interval;

	modport source(output valid, min_edge_interval, input ready);
	modport sink(input valid, min_edge_interval, output ready);
endinterface

[src/htv_classifier.sv]
// ----------------------------------------------------------------------------
// htv_classifier
// Combinational check of one edge against the stored code and stamp.
// ----------------------------------------------------------------------------
module htv_classifier (
	input  logic [htv_pkg::CODE_W-1:0]  hall_code,
	input  logic [htv_pkg::STAMP_W-1:0] timestamp,
	input  logic                        direction,
	input  logic [htv_pkg::CODE_W-1:0]  prev_code,
	input  logic [htv_pkg::STAMP_W-1:0] last_time,
	input  logic [htv_pkg::MIN_W-1:0]   min_interval,
	output htv_pkg::verdict_t           verdict
);

	logic [htv_pkg::STAMP_W-1:0] delta;
	logic [htv_pkg::CODE_W-1:0]  diff;
	logic                        too_soon;
	logic                        impossible;
	logic                        one_bit;
	logic                        in_sequence;

	assign delta       = timestamp - last_time;
	assign too_soon    = delta < htv_pkg::STAMP_W'(min_interval);
	assign impossible  = (hall_code == htv_pkg::CODE_ALL_LOW) ||
	                     (hall_code == htv_pkg::CODE_ALL_HIGH);
	assign diff        = prev_code ^ hall_code;
	assign one_bit     = (diff == htv_pkg::BIT_U) || (diff == htv_pkg::BIT_V) ||
	                     (diff == htv_pkg::BIT_W);
	assign in_sequence = htv_pkg::successor(prev_code, direction) == hall_code;

	always_comb begin
		verdict.upd_time = !too_soon;
		verdict.upd_code = !too_soon && !impossible;
		priority if (too_soon) begin
			verdict.status = htv_pkg::ST_TOO_SOON;
		end else if (impossible) begin
			verdict.status = htv_pkg::ST_IMPOSSIBLE;
		end else if (!one_bit) begin
			verdict.status = htv_pkg::ST_MULTI_BIT;
		end else if (!in_sequence) begin
			verdict.status = (direction == htv_pkg::DIR_CW) ? htv_pkg::ST_WRONG_CW
			                                                : htv_pkg::ST_WRONG_CCW;
		end else begin
			verdict.status = htv_pkg::ST_VALID;
		end
	end

endmodule

[src/htv_counters.sv]
// ----------------------------------------------------------------------------
// htv_counters
// Bank of wrapping error counters, one per error status.
// ----------------------------------------------------------------------------
module htv_counters (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        inc_en,
	input  htv_pkg::status_t            status,
	output logic [htv_pkg::COUNT_W-1:0] count
);

	logic [htv_pkg::COUNT_W-1:0]   cnt_q [htv_pkg::NUM_ERR];
	logic [htv_pkg::ERR_IDX_W-1:0] idx;
	logic                          is_err;

	assign is_err = status != htv_pkg::ST_VALID;
	// error statuses are 1..NUM_ERR; entry k holds status k+1
	assign idx    = htv_pkg::ERR_IDX_W'(status) - htv_pkg::ERR_IDX_W'(1);
	assign count  = is_err ? cnt_q[idx] + htv_pkg::COUNT_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < htv_pkg::NUM_ERR; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (inc_en && is_err) begin
			cnt_q[idx] <= count;
		end
	end

endmodule

[src/hall_transition_validator.sv]
// ----------------------------------------------------------------------------
// hall_transition_validator
// Classifies each Hall-sensor edge and reports a status with its error count.
// ----------------------------------------------------------------------------
// Usage:
//   hall    - edge requests: 3-bit Hall code, 32-bit timer stamp, direction.
//   verdict - one request per edge: status and the error counter after its
//             increment (zero for a valid edge).
//   cfg     - write of min_edge_interval; always ready, take it while idle.
// Pipeline: two registers, input stage s1 and result stage s2; an accepted
//   edge is registered in s1, then in s2, which drives the verdict channel.
// Throughput: one edge per cycle unless verdict stalls. The check, the state
//   update and the single counter increment all fit between the s1 and s2
//   registers, and the stored code, stamp and counters are written at the
//   same edge that loads s2, so the next edge in s1 always sees fresh state.
// Stall: when verdict is not taken, s2 holds its request and s1 holds the
//   next edge; hall.ready drops only when both are full.
// Reset: both stages empty, stored code and stamp zero, all error counters
//   zero, min_edge_interval back to 5.
// ----------------------------------------------------------------------------
module hall_transition_validator (
	input  logic          clk,
	input  logic          arst_n,
	htv_cfg_if.sink       cfg,
	htv_edge_if.sink      hall,
	htv_verdict_if.source verdict
);

	// configuration and stored state
	logic [htv_pkg::MIN_W-1:0]   min_q;
	logic [htv_pkg::CODE_W-1:0]  prev_code_q;
	logic [htv_pkg::STAMP_W-1:0] last_time_q;

	// input stage
	logic                        valid_s1;
	logic [htv_pkg::CODE_W-1:0]  code_s1;
	logic [htv_pkg::STAMP_W-1:0] stamp_s1;
	logic                        dir_s1;

	// result stage
	logic                        valid_s2;
	htv_pkg::status_t            status_s2;
	logic [htv_pkg::COUNT_W-1:0] count_s2;

	htv_pkg::verdict_t           check;
	logic [htv_pkg::COUNT_W-1:0] count;
	logic                        advance;
	logic                        take;

	// s1 moves into s2 when s2 is empty or being drained this cycle
	assign advance    = valid_s1 && (!valid_s2 || verdict.ready);
	assign hall.ready = !valid_s1 || advance;
	assign take       = hall.valid && hall.ready;
	assign cfg.ready  = 1'b1;

	htv_classifier u_classifier (
		.hall_code    (code_s1),
		.timestamp    (stamp_s1),
		.direction    (dir_s1),
		.prev_code    (prev_code_q),
		.last_time    (last_time_q),
		.min_interval (min_q),
		.verdict      (check)
	);

	// counters bump only when the edge actually leaves s1
	htv_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.inc_en (advance),
		.status (check.status),
		.count  (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= htv_pkg::MIN_RESET;
		end else if (cfg.valid) begin
			min_q <= cfg.min_edge_interval;
		end
	end

	// stored code and stamp: too soon keeps both, impossible keeps the code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= '0;
			last_time_q <= '0;
		end else if (advance) begin
			if (check.upd_time) begin
				last_time_q <= stamp_s1;
			end
			if (check.upd_code) begin
				prev_code_q <= code_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hall.ready) begin
			valid_s1 <= hall.valid;
		end
	end

	// payload of s1 loads on acceptance only
	always_ff @(posedge clk) begin
		if (take) begin
			code_s1  <= hall.hall_code;
			stamp_s1 <= hall.timestamp;
			dir_s1   <= hall.direction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (verdict.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the verdict while the receiver stalls
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= check.status;
			count_s2  <= count;
		end
	end

	assign verdict.valid       = valid_s2;
	assign verdict.status      = status_s2;
	assign verdict.error_count = count_s2;

endmodule

[src/htv_checker.sv]
// ----------------------------------------------------------------------------
// htv_checker
// Port-level assertions for the Hall transition validator.
// ----------------------------------------------------------------------------
module htv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [htv_pkg::CODE_W-1:0]  in_code,
	input logic                        out_valid,
	input logic                        out_ready,
	input htv_pkg::status_t            out_status,
	input logic [htv_pkg::COUNT_W-1:0] out_count
);

	// a stalled verdict holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
		else $error("verdict changed while stalled");

	// a valid edge reports a zero count
	a_valid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == htv_pkg::ST_VALID) |-> out_count == '0)
		else $error("valid edge with nonzero count");

	// an all-low or all-high code comes out as too soon or impossible
	a_impossible: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		((in_code == htv_pkg::CODE_ALL_LOW) || (in_code == htv_pkg::CODE_ALL_HIGH))
		##1 (!out_valid || out_ready)
		|=> out_valid &&
		((out_status == htv_pkg::ST_TOO_SOON) || (out_status == htv_pkg::ST_IMPOSSIBLE)))
		else $error("impossible code misclassified");

	// with the verdict side stalled and full, no new edge may be taken twice over
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready)
		else $error("edge accepted with both stages full");

endmodule

bind hall_transition_validator htv_checker u_htv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (hall.valid),
	.in_ready   (hall.ready),
	.in_code    (hall.hall_code),
	.out_valid  (verdict.valid),
	.out_ready  (verdict.ready),
	.out_status (verdict.status),
	.out_count  (verdict.error_count)
);
